>>> rtl/neighbor_reply_snoop_parser_unit_defines.svh
// assertion macros for the neighbor reply snoop parser
// no dependencies; expects clk and rst in the scope of each use
`ifndef NEIGHBOR_REPLY_SNOOP_PARSER_UNIT_DEFINES_SVH
`define NEIGHBOR_REPLY_SNOOP_PARSER_UNIT_DEFINES_SVH

// checked outside reset only
`define NRSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define NRSP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/nrsp_pkg.sv
// shared types and constants for the neighbor reply snoop parser
// no dependencies
`default_nettype none

package nrsp_pkg;

  // depth of the queue between front and back, a power of two
  localparam int QUEUE_DEPTH = 4;

  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_QINQ = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;

  localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
  localparam logic [7:0]  NEXT_HDR_ICMP6 = 8'd58;
  localparam logic [7:0]  ICMP6_NA       = 8'd136;
  localparam logic [7:0]  OPT_TGT_LLADDR = 8'd2;

  localparam logic [15:0] VID_MASK = 16'h0fff;

  // one frame byte as classified by the front
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] port;
    logic [11:0] vid;
    logic        eth_src;   // inside the ethernet source address
    logic        eth_type;  // inside the outer ethertype
    logic        eth_end;   // final byte of the ethernet header
    logic        beyond;    // offset counter already saturated
  } byte_info_t;

endpackage

`default_nettype wire

>>> rtl/nrsp_stream_if.sv
// valid/ready channel interfaces for frame bytes and neighbor results
// no dependencies
`default_nettype none

interface nrsp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  packet_byte;
  logic        last_byte;
  logic [15:0] ingress_port;
  logic        tag_present;
  logic [15:0] tag_control;

  modport source (output valid, packet_byte, last_byte, ingress_port, tag_present,
                  tag_control, input ready);
  modport sink (input valid, packet_byte, last_byte, ingress_port, tag_present,
                tag_control, output ready);
endinterface

interface nrsp_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] neighbor_mac;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic        family;
  logic [11:0] vlan_id;
  logic [15:0] port_out;

  modport source (output valid, neighbor_mac, addr_high, addr_low, family, vlan_id,
                  port_out, input ready);
  modport sink (input valid, neighbor_mac, addr_high, addr_low, family, vlan_id,
                port_out, output ready);
endinterface

`default_nettype wire

>>> rtl/nrsp_front.sv
// front: accepts frame bytes, tracks the byte offset and classifies header bytes
// depends on nrsp_pkg and nrsp_in_if
`default_nettype none

module nrsp_front import nrsp_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  nrsp_in_if.sink                frame_in,
  output byte_info_t             item,
  output logic [OFFSET_BITS-1:0] offset,
  output logic                   push,
  input  logic                   push_ready
);

  localparam logic [OFFSET_BITS-1:0] OffsetCap    = '1;
  localparam logic [OFFSET_BITS-1:0] EthSrcFirst  = OFFSET_BITS'(6);
  localparam logic [OFFSET_BITS-1:0] EthSrcLast   = OFFSET_BITS'(11);
  localparam logic [OFFSET_BITS-1:0] EthTypeFirst = OFFSET_BITS'(12);
  localparam logic [OFFSET_BITS-1:0] EthTypeLast  = OFFSET_BITS'(13);

  logic [OFFSET_BITS-1:0] byte_offset;
  logic                   beyond;
  logic                   accept;

  assign frame_in.ready = push_ready;
  assign push           = frame_in.valid;
  assign accept         = frame_in.valid && push_ready;
  assign offset         = byte_offset;

  always_comb begin
    item.data     = frame_in.packet_byte;
    item.last     = frame_in.last_byte;
    item.port     = frame_in.ingress_port;
    item.vid      = frame_in.tag_present ? 12'(frame_in.tag_control & VID_MASK) : 12'd0;
    item.eth_src  = (byte_offset >= EthSrcFirst) && (byte_offset <= EthSrcLast);
    item.eth_type = (byte_offset >= EthTypeFirst) && (byte_offset <= EthTypeLast);
    item.eth_end  = (byte_offset == EthTypeLast);
    item.beyond   = beyond;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0;
      beyond      <= 1'b0;
    end else if (accept) begin
      if (frame_in.last_byte) begin
        byte_offset <= '0;
        beyond      <= 1'b0;
      end else if (byte_offset == OffsetCap) begin
        beyond <= 1'b1;
      end else begin
        byte_offset <= byte_offset + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/nrsp_queue.sv
// short queue between front and back of the parser
// depends on nrsp_pkg
`default_nettype none

module nrsp_queue import nrsp_pkg::*; #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   push_ready,
  input  byte_info_t             item_in,
  input  logic [OFFSET_BITS-1:0] offset_in,
  input  logic                   pop,
  output logic                   head_valid,
  output byte_info_t             item_out,
  output logic [OFFSET_BITS-1:0] offset_out
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = PtrW + 1;

  byte_info_t             slot_item   [QUEUE_DEPTH];
  logic [OFFSET_BITS-1:0] slot_offset [QUEUE_DEPTH];
  logic [PtrW-1:0]        wr_ptr;
  logic [PtrW-1:0]        rd_ptr;
  logic [CntW-1:0]        count;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready = (count != CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;
  assign item_out   = slot_item[rd_ptr];
  assign offset_out = slot_offset[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_item[wr_ptr]   <= item_in;
      slot_offset[wr_ptr] <= offset_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nrsp_back.sv
// back: per-byte parser state machine, field capture and result register
// depends on nrsp_pkg and nrsp_out_if
`default_nettype none

module nrsp_back import nrsp_pkg::*; #(
  parameter int MAX_TAGS    = 2,
  parameter int MAX_OPTIONS = 3,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  byte_info_t             item,
  input  logic [OFFSET_BITS-1:0] offset,
  output logic                   pop,
  nrsp_out_if.source             result_out
);

  localparam int TagW = (MAX_TAGS < 1) ? 1 : $clog2(MAX_TAGS + 1);
  localparam int OptW = $clog2(MAX_OPTIONS + 1);

  typedef enum logic [9:0] {
    ST_ETH     = 10'b00_0000_0001,
    ST_TAG     = 10'b00_0000_0010,
    ST_ARP     = 10'b00_0000_0100,
    ST_IP6     = 10'b00_0000_1000,
    ST_ICMP    = 10'b00_0001_0000,
    ST_OPT     = 10'b00_0010_0000,
    ST_OPT_MAC = 10'b00_0100_0000,
    ST_USE_SRC = 10'b00_1000_0000,
    ST_USE_OPT = 10'b01_0000_0000,
    ST_REJECT  = 10'b10_0000_0000
  } stage_t;

  // control state
  stage_t                 stage, stage_next;
  logic [TagW-1:0]        tag_count, tag_count_next;
  logic [OptW-1:0]        option_count, option_count_next;
  logic [OFFSET_BITS-1:0] section_start, section_start_next;
  logic                   arp_ok, arp_ok_next;
  logic                   tlla, tlla_next;
  // captured fields
  logic [15:0]            type_shift, type_shift_next;
  logic [7:0]             hw_len, hw_len_next;
  logic [47:0]            src_mac, src_mac_next;
  logic [47:0]            found_mac, found_mac_next;
  logic [63:0]            cap_high, cap_high_next;
  logic [63:0]            cap_low, cap_low_next;
  // result register
  logic                   out_valid;
  logic [47:0]            res_mac;
  logic [63:0]            res_high;
  logic [63:0]            res_low;
  logic                   res_family;
  logic [11:0]            res_vid;
  logic [15:0]            res_port;

  logic                   slot_free;
  logic [OFFSET_BITS-1:0] r;
  logic [OFFSET_BITS-1:0] next_start;
  logic [15:0]            ts_shift;
  logic [47:0]            mac_shift;
  logic [TagW-1:0]        tag_inc;
  logic [OptW-1:0]        opt_inc;
  logic [8:0]             arp_lo;
  logic [8:0]             arp_hi;
  logic [8:0]             arp_need;
  logic [10:0]            span_end;
  logic                   is_arp_res;
  logic                   is_nd_res;
  logic                   emit;

  function automatic stage_t dispatch_stage(input logic [15:0] etype, input logic tags_left);
    stage_t st;
    priority if ((etype == ETYPE_VLAN || etype == ETYPE_QINQ) && tags_left) st = ST_TAG;
    else if (etype == ETYPE_IPV6) st = ST_IP6;
    else if (etype == ETYPE_ARP) st = ST_ARP;
    else st = ST_REJECT;
    return st;
  endfunction

  assign slot_free  = !out_valid || result_out.ready;
  assign pop        = head_valid && (!item.last || slot_free);
  assign r          = offset - section_start;
  assign next_start = offset + 1'b1;
  assign ts_shift   = {type_shift[7:0], item.data};
  assign mac_shift  = {found_mac[39:0], item.data};
  assign tag_inc    = tag_count + 1'b1;
  assign opt_inc    = option_count + 1'b1;
  assign arp_lo     = {1'b0, hw_len} + 9'd8;
  assign arp_hi     = arp_lo + 9'd3;
  assign arp_need   = (hw_len < 8'd2) ? 9'd13 : ({1'b0, hw_len} + 9'd11);
  assign span_end   = {hw_len, 3'b000} - 11'd1;

  always_comb begin
    stage_next         = stage;
    tag_count_next     = tag_count;
    option_count_next  = option_count;
    section_start_next = section_start;
    arp_ok_next        = arp_ok;
    tlla_next          = tlla;
    type_shift_next    = type_shift;
    hw_len_next        = hw_len;
    src_mac_next       = src_mac;
    found_mac_next     = found_mac;
    cap_high_next      = cap_high;
    cap_low_next       = cap_low;

    if (pop) begin
      if (item.beyond) begin
        // past the offset limit no field is seen
        if (stage == ST_OPT) stage_next = ST_USE_SRC;
        else if (stage == ST_OPT_MAC) stage_next = ST_REJECT;
      end else begin
        unique case (stage)
          ST_ETH: begin
            if (item.eth_src) src_mac_next = {src_mac[39:0], item.data};
            if (item.eth_type) type_shift_next = ts_shift;
            if (item.eth_end) begin
              section_start_next = next_start;
              stage_next = dispatch_stage(ts_shift, tag_count < TagW'(MAX_TAGS));
            end
          end
          ST_TAG: begin
            if (r >= OFFSET_BITS'(2)) type_shift_next = ts_shift;
            if (r == OFFSET_BITS'(3)) begin
              tag_count_next     = tag_inc;
              section_start_next = next_start;
              stage_next = dispatch_stage(ts_shift, tag_inc < TagW'(MAX_TAGS));
            end
          end
          ST_ARP: begin
            if (r == OFFSET_BITS'(4)) hw_len_next = item.data;
            if (r == OFFSET_BITS'(6) || r == OFFSET_BITS'(7)) type_shift_next = ts_shift;
            if (r == OFFSET_BITS'(7) && ts_shift != ARP_OP_REPLY) begin
              stage_next = ST_REJECT;
            end else begin
              // sender hardware address, then sender protocol address
              if (r >= OFFSET_BITS'(8) && r <= OFFSET_BITS'(13)) found_mac_next = mac_shift;
              if (r >= OFFSET_BITS'(arp_lo) && r <= OFFSET_BITS'(arp_hi))
                cap_low_next = {cap_low[55:0], item.data};
              if (r == OFFSET_BITS'(arp_need)) arp_ok_next = 1'b1;
            end
          end
          ST_IP6: begin
            if (r == OFFSET_BITS'(6) && item.data != NEXT_HDR_ICMP6) begin
              stage_next = ST_REJECT;
            end else if (r == OFFSET_BITS'(39)) begin
              section_start_next = next_start;
              stage_next = ST_ICMP;
            end
          end
          ST_ICMP: begin
            if (r == OFFSET_BITS'(0) && item.data != ICMP6_NA) begin
              stage_next = ST_REJECT;
            end else begin
              if (r >= OFFSET_BITS'(8) && r <= OFFSET_BITS'(15))
                cap_high_next = {cap_high[55:0], item.data};
              if (r >= OFFSET_BITS'(16) && r <= OFFSET_BITS'(23))
                cap_low_next = {cap_low[55:0], item.data};
              if (r == OFFSET_BITS'(23)) begin
                section_start_next = next_start;
                option_count_next  = '0;
                tlla_next          = 1'b0;
                stage_next         = ST_OPT;
              end
            end
          end
          ST_OPT: begin
            if (r == OFFSET_BITS'(0)) begin
              tlla_next = (item.data == OPT_TGT_LLADDR);
            end else if (r == OFFSET_BITS'(1)) begin
              hw_len_next = item.data;
              if (item.data == 8'd0) stage_next = tlla ? ST_OPT_MAC : ST_USE_SRC;
            end else begin
              if (tlla && r <= OFFSET_BITS'(7)) found_mac_next = mac_shift;
              if (r == OFFSET_BITS'(span_end)) begin
                if (tlla) begin
                  stage_next = ST_USE_OPT;
                end else begin
                  option_count_next = opt_inc;
                  if (opt_inc >= OptW'(MAX_OPTIONS)) stage_next = ST_USE_SRC;
                  else section_start_next = next_start;
                end
              end
            end
          end
          ST_OPT_MAC: begin
            if (r >= OFFSET_BITS'(2) && r <= OFFSET_BITS'(7)) found_mac_next = mac_shift;
            if (r == OFFSET_BITS'(7)) stage_next = ST_USE_OPT;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign is_arp_res = (stage_next == ST_ARP) && arp_ok_next;
  assign is_nd_res  = (stage_next == ST_OPT) || (stage_next == ST_USE_SRC) ||
                      (stage_next == ST_USE_OPT);
  assign emit       = pop && item.last && (is_arp_res || is_nd_res);

  always_ff @(posedge clk) begin
    if (rst || (pop && item.last)) begin
      stage         <= ST_ETH;
      tag_count     <= '0;
      option_count  <= '0;
      section_start <= '0;
      arp_ok        <= 1'b0;
      tlla          <= 1'b0;
    end else begin
      stage         <= stage_next;
      tag_count     <= tag_count_next;
      option_count  <= option_count_next;
      section_start <= section_start_next;
      arp_ok        <= arp_ok_next;
      tlla          <= tlla_next;
    end
  end

  always_ff @(posedge clk) begin
    type_shift <= type_shift_next;
    hw_len     <= hw_len_next;
    src_mac    <= src_mac_next;
    found_mac  <= found_mac_next;
    cap_high   <= cap_high_next;
    cap_low    <= cap_low_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_mac    <= (is_arp_res || stage_next == ST_USE_OPT) ? found_mac_next : src_mac_next;
      res_high   <= is_arp_res ? 64'd0 : cap_high_next;
      res_low    <= is_arp_res ? {32'd0, cap_low_next[31:0]} : cap_low_next;
      res_family <= !is_arp_res;
      res_vid    <= item.vid;
      res_port   <= item.port;
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.neighbor_mac = res_mac;
  assign result_out.addr_high    = res_high;
  assign result_out.addr_low     = res_low;
  assign result_out.family       = res_family;
  assign result_out.vlan_id      = res_vid;
  assign result_out.port_out     = res_port;

endmodule

`default_nettype wire

>>> rtl/neighbor_reply_snoop_parser_unit.sv
// top level of the neighbor reply snoop parser: front, queue and back
// depends on nrsp_pkg, nrsp_stream_if, nrsp_front, nrsp_queue, nrsp_back
//
// usage
// - frame_in carries one frame byte per transaction with its last-byte mark,
//   ingress port and stripped vlan tag; metadata is taken from the last byte
// - result_out carries at most one neighbor entry per frame: arp replies give
//   the sender mac and ipv4 address, neighbor advertisements give the target
//   ipv6 address and the target link-layer mac or else the ethernet source
// - throughput: one byte per cycle sustained unless result_out stalls; the
//   front counts offsets and classifies header bytes, the back updates its
//   parser state once per byte from the queue head; a frame's last byte is
//   queued, then its parser step loads the result register
// - rejected frames, and frames cut before a full entry, give no result
// - reset (synchronous, active high) empties the queue, drops a pending result
//   and returns the parser to the ethernet header
// - when result_out stalls the result is held; further bytes keep flowing
//   until the parser reaches the next last byte, then the queue fills and
//   frame_in.ready drops
`default_nettype none

module neighbor_reply_snoop_parser_unit import nrsp_pkg::*; #(
  parameter int MAX_TAGS    = 2,
  parameter int MAX_OPTIONS = 3,
  parameter int OFFSET_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  nrsp_in_if.sink    frame_in,
  nrsp_out_if.source result_out
);

  // front to queue
  byte_info_t             front_item;
  logic [OFFSET_BITS-1:0] front_offset;
  logic                   front_push;
  logic                   front_ready;
  // queue to back
  byte_info_t             head_item;
  logic [OFFSET_BITS-1:0] head_offset;
  logic                   head_valid;
  logic                   head_pop;

  // offset tracking and header byte classification
  nrsp_front #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .item       (front_item),
    .offset     (front_offset),
    .push       (front_push),
    .push_ready (front_ready)
  );

  // decouples byte intake from a stalled result
  nrsp_queue #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (front_push),
    .push_ready (front_ready),
    .item_in    (front_item),
    .offset_in  (front_offset),
    .pop        (head_pop),
    .head_valid (head_valid),
    .item_out   (head_item),
    .offset_out (head_offset)
  );

  // parser state machine and result register
  nrsp_back #(
    .MAX_TAGS    (MAX_TAGS),
    .MAX_OPTIONS (MAX_OPTIONS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .item       (head_item),
    .offset     (head_offset),
    .pop        (head_pop),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

>>> rtl/nrsp_checker.sv
// port-level checks of the neighbor reply snoop parser, bound to the top level
// depends on neighbor_reply_snoop_parser_unit_defines.svh
`default_nettype none
`include "neighbor_reply_snoop_parser_unit_defines.svh"

module nrsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        frame_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [47:0] neighbor_mac,
  input logic [63:0] addr_high,
  input logic [63:0] addr_low,
  input logic        family
);

  // reset drops any pending result
  `NRSP_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !result_valid, "result valid after reset")

  // stalled result holds
  `NRSP_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid && $stable(neighbor_mac) && $stable(addr_high) && $stable(addr_low) && $stable(family), "stalled result changed")

  // arp results carry only an ipv4 address
  `NRSP_ASSERT(a_ipv4_upper_zero, result_valid && !family |-> addr_high == 64'd0 && addr_low[63:32] == 32'd0, "ipv4 result with upper address bits set")

  // the queue drains whenever the result slot is free
  `NRSP_ASSERT(a_ready_when_drained, !result_valid || result_ready |=> frame_ready, "input blocked although output was free")

endmodule

bind neighbor_reply_snoop_parser_unit nrsp_checker u_nrsp_checker (
  .clk          (clk),
  .rst          (rst),
  .frame_ready  (frame_in.ready),
  .result_valid (result_out.valid),
  .result_ready (result_out.ready),
  .neighbor_mac (result_out.neighbor_mac),
  .addr_high    (result_out.addr_high),
  .addr_low     (result_out.addr_low),
  .family       (result_out.family)
);

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for neighbor_reply_snoop_parser_unit: byte-level predictor,
// directed frames for each parser case, then random frames with idle and stall bursts
// depends on nrsp_pkg, nrsp_stream_if and the rtl of the parser unit
`timescale 1ns / 100ps

module tb_top import nrsp_pkg::*;;

  localparam int TAG_LIMIT      = 2;
  localparam int OPTION_LIMIT   = 3;
  localparam int OFFSET_W       = 16;
  localparam int unsigned OFFSET_CAP = (1 << OFFSET_W) - 1;

  localparam int RAND_BEATS     = 850;   // random frame bytes to send at least
  localparam int RAND_RESULTS   = 48;    // random neighbor entries to see at least
  localparam int CALM_BEATS     = 720;   // from here on nobody idles
  localparam int DRAIN_CYCLES   = 8;     // wait after the last byte for its result to land
  localparam int STALL_LIMIT    = 2000;  // cycles with no transaction before giving up
  localparam int LONG_BODY      = 65600; // pushes the byte offset past saturation

  // parser stages of the predictor
  typedef enum logic [3:0] {
    PS_ETH, PS_TAG, PS_ARP, PS_IP6, PS_ICMP, PS_OPT, PS_OPT_MAC,
    PS_USE_SRC, PS_USE_OPT, PS_REJECT
  } parse_stage_e;

  // one frame byte with its metadata
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] port;
    logic        tp;
    logic [15:0] tc;
  } frame_beat_t;

  // one neighbor table entry
  typedef struct packed {
    logic [47:0] mac;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        fam;
    logic [11:0] vid;
    logic [15:0] port;
  } nbr_entry_t;

  logic clk;
  logic rst;

  nrsp_in_if  frame_if ();
  nrsp_out_if result_if ();

  neighbor_reply_snoop_parser_unit #(
    .MAX_TAGS    (TAG_LIMIT),
    .MAX_OPTIONS (OPTION_LIMIT),
    .OFFSET_BITS (OFFSET_W)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_if),
    .result_out (result_if)
  );

  // stimulus and scoreboard storage
  frame_beat_t beat_queue [$];     // bytes waiting for the driver
  nbr_entry_t  nbr_expected [$];   // neighbor entries the parser still owes
  logic [7:0]  fbuf [$];           // frame under construction

  frame_beat_t cur_beat;
  frame_beat_t seen_beat;
  bit          beat_live;
  bit          in_taken;
  bit          hold_input;
  bit          calm;
  int          gap_left;
  int          stall_left;
  int          quiet_cycles;
  int          err_count;
  int          results_due;
  int          beats_queued;

  // predictor state, cleared at every frame end
  int unsigned  off_now;
  parse_stage_e stage;
  logic [15:0]  shift16;
  int           tags_seen;
  int           opts_seen;
  int unsigned  sect_base;
  logic [47:0]  eth_src_mac;
  logic [47:0]  nbr_mac;
  logic [63:0]  ip_hi;
  logic [63:0]  ip_lo;
  logic [7:0]   len_field;
  bit           arp_done;
  bit           opt_is_tlla;
  bit           past_cap;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic clear_parse();
    off_now     = 0;
    stage       = PS_ETH;
    shift16     = '0;
    tags_seen   = 0;
    opts_seen   = 0;
    sect_base   = 0;
    eth_src_mac = '0;
    nbr_mac     = '0;
    ip_hi       = '0;
    ip_lo       = '0;
    len_field   = '0;
    arp_done    = 0;
    opt_is_tlla = 0;
    past_cap    = 0;
  endtask

  // choose the stage after an ethertype or a tag has been fully read
  task automatic pick_next_header(input int unsigned p);
    sect_base = p + 1;
    if ((shift16 == ETYPE_VLAN || shift16 == ETYPE_QINQ) && tags_seen < TAG_LIMIT) begin
      stage = PS_TAG;
    end else if (shift16 == ETYPE_IPV6) begin
      stage = PS_IP6;
    end else if (shift16 == ETYPE_ARP) begin
      stage = PS_ARP;
    end else begin
      stage = PS_REJECT;
    end
  endtask

  task automatic parse_byte(input int unsigned p, input logic [7:0] b);
    int unsigned r, lo, need, span;
    // past the saturated offset only a pending option search is resolved
    if (past_cap) begin
      if (stage == PS_OPT) stage = PS_USE_SRC;
      else if (stage == PS_OPT_MAC) stage = PS_REJECT;
      return;
    end
    r = p - sect_base;
    case (stage)
      PS_ETH: begin
        if (p >= 6 && p <= 11) eth_src_mac = {eth_src_mac[39:0], b};
        if (p >= 12) shift16 = {shift16[7:0], b};
        if (p == 13) pick_next_header(p);
      end
      PS_TAG: begin
        if (r >= 2) shift16 = {shift16[7:0], b};
        if (r == 3) begin
          tags_seen++;
          pick_next_header(p);
        end
      end
      PS_ARP: begin
        if (r == 4) len_field = b;
        if (r == 6 || r == 7) shift16 = {shift16[7:0], b};
        if (r == 7 && shift16 != ARP_OP_REPLY) begin
          stage = PS_REJECT;
        end else begin
          if (r >= 8 && r <= 13) nbr_mac = {nbr_mac[39:0], b};
          lo = 8 + len_field;
          if (r >= lo && r <= lo + 3) ip_lo = {32'b0, ip_lo[23:0], b};
          need = 11 + len_field;
          if (need < 13) need = 13;
          if (r == need) arp_done = 1;
        end
      end
      PS_IP6: begin
        if (r == 6 && b != NEXT_HDR_ICMP6) begin
          stage = PS_REJECT;
        end else if (r == 39) begin
          sect_base = p + 1;
          stage     = PS_ICMP;
        end
      end
      PS_ICMP: begin
        if (r == 0 && b != ICMP6_NA) begin
          stage = PS_REJECT;
        end else begin
          if (r >= 8 && r <= 15) ip_hi = {ip_hi[55:0], b};
          if (r >= 16 && r <= 23) ip_lo = {ip_lo[55:0], b};
          if (r == 23) begin
            sect_base   = p + 1;
            opts_seen   = 0;
            opt_is_tlla = 0;
            stage       = PS_OPT;
          end
        end
      end
      PS_OPT: begin
        if (r == 0) begin
          opt_is_tlla = (b == OPT_TGT_LLADDR);
        end else if (r == 1) begin
          len_field = b;
          // zero length: target option still expects a mac, anything else stops
          if (b == 0) stage = opt_is_tlla ? PS_OPT_MAC : PS_USE_SRC;
        end else begin
          if (opt_is_tlla && r <= 7) nbr_mac = {nbr_mac[39:0], b};
          span = int'(len_field) * 8;
          if (r == span - 1) begin
            if (opt_is_tlla) begin
              stage = PS_USE_OPT;
            end else begin
              opts_seen++;
              if (opts_seen >= OPTION_LIMIT) stage = PS_USE_SRC;
              else sect_base = p + 1;
            end
          end
        end
      end
      PS_OPT_MAC: begin
        if (r >= 2 && r <= 7) nbr_mac = {nbr_mac[39:0], b};
        if (r == 7) stage = PS_USE_OPT;
      end
      default: ;
    endcase
  endtask

  // advance the predictor by one accepted byte; the last byte may owe an entry
  task automatic predict_beat(input frame_beat_t bt);
    int unsigned p;
    nbr_entry_t  e;
    bit          emit;
    logic [15:0] vid_word;
    p = off_now;
    parse_byte(p, bt.data);
    if (p < OFFSET_CAP) off_now = p + 1;
    else past_cap = 1;
    if (bt.last) begin
      emit = 0;
      e    = '0;
      if (stage == PS_ARP && arp_done) begin
        e.mac = nbr_mac;
        e.hi  = '0;
        e.lo  = {32'b0, ip_lo[31:0]};
        e.fam = 1'b0;
        emit  = 1;
      end else if (stage == PS_OPT || stage == PS_USE_SRC || stage == PS_USE_OPT) begin
        e.mac = (stage == PS_USE_OPT) ? nbr_mac : eth_src_mac;
        e.hi  = ip_hi;
        e.lo  = ip_lo;
        e.fam = 1'b1;
        emit  = 1;
      end
      if (emit) begin
        vid_word = bt.tp ? (bt.tc & VID_MASK) : 16'h0000;
        e.vid    = vid_word[11:0];
        e.port   = bt.port;
        nbr_expected.push_back(e);
        results_due++;
      end
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic check_entry();
    nbr_entry_t want;
    if (nbr_expected.size() == 0) begin
      err_count++;
      $display("%0t: unexpected entry, expected none, actual mac %h addr %h_%h port %h",
               $time, result_if.neighbor_mac, result_if.addr_high, result_if.addr_low,
               result_if.port_out);
    end else begin
      want = nbr_expected.pop_front();
      check_field("neighbor_mac", want.mac,  result_if.neighbor_mac);
      check_field("addr_high",    want.hi,   result_if.addr_high);
      check_field("addr_low",     want.lo,   result_if.addr_low);
      check_field("family",       want.fam,  result_if.family);
      check_field("vlan_id",      want.vid,  result_if.vlan_id);
      check_field("port_out",     want.port, result_if.port_out);
    end
  endtask

  // ---------------------------------------------------------------------------
  // frame construction
  // ---------------------------------------------------------------------------

  task automatic put_rand(input int n);
    for (int i = 0; i < n; i++) fbuf.push_back($urandom_range(0, 255));
  endtask

  task automatic put16(input logic [15:0] v);
    fbuf.push_back(v[15:8]);
    fbuf.push_back(v[7:0]);
  endtask

  // destination, source and ntags stacked tags; the caller adds the ethertype
  task automatic put_eth_hdr(input int ntags);
    put_rand(12);
    for (int i = 0; i < ntags; i++) begin
      put16($urandom_range(0, 1) ? ETYPE_VLAN : ETYPE_QINQ);
      put_rand(2);
    end
  endtask

  // arp header plus just enough bytes to complete the sender addresses, then extra
  task automatic put_arp_body(input logic [7:0] hln, input logic [15:0] op, input int extra);
    int need;
    put16(16'h0001);
    put16(16'h0800);
    fbuf.push_back(hln);
    fbuf.push_back(8'd4);
    put16(op);
    need = 11 + hln;
    if (need < 13) need = 13;
    put_rand(need - 7 + extra);
  endtask

  // 40-byte ipv6 header and the fixed 24 bytes of a neighbor advertisement
  task automatic put_na_hdr(input logic [7:0] nh, input logic [7:0] itype);
    put_rand(6);
    fbuf.push_back(nh);
    put_rand(33);
    fbuf.push_back(itype);
    put_rand(23);
  endtask

  // zero-length options are followed by six bytes for a possible mac
  task automatic put_opt(input logic [7:0] kind, input logic [7:0] len);
    fbuf.push_back(kind);
    fbuf.push_back(len);
    put_rand((len == 0) ? 6 : int'(len) * 8 - 2);
  endtask

  // hand the frame to the driver, cutting drop bytes off its end
  task automatic send_frame(input int drop, input logic [15:0] port, input logic tp,
                            input logic [15:0] tc);
    int n;
    frame_beat_t bt;
    n = fbuf.size() - drop;
    if (n < 1) n = 1;
    for (int i = 0; i < n; i++) begin
      bt.data = fbuf[i];
      bt.last = (i == n - 1);
      bt.port = port;
      bt.tp   = tp;
      bt.tc   = tc;
      beat_queue.push_back(bt);
    end
    beats_queued += n;
    fbuf.delete();
  endtask

  task automatic send_any(input int drop);
    send_frame(drop, $urandom_range(0, 65535), $urandom_range(0, 1), $urandom_range(0, 65535));
  endtask

  task automatic make_random_frame();
    int kind, nopt, ntag, drop;
    logic [7:0] hln, okind, olen, nh, itype;
    logic [15:0] op;
    kind = $urandom_range(0, 99);
    ntag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, TAG_LIMIT) : 0;
    drop = 0;
    if (kind < 40) begin
      // neighbor advertisement, mostly well formed, with a random option list
      nh    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : NEXT_HDR_ICMP6;
      itype = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : ICMP6_NA;
      put_eth_hdr(ntag);
      put16(ETYPE_IPV6);
      put_na_hdr(nh, itype);
      nopt = $urandom_range(0, 4);
      for (int i = 0; i < nopt; i++) begin
        okind = ($urandom_range(0, 2) == 0) ? OPT_TGT_LLADDR : $urandom_range(0, 255);
        case ($urandom_range(0, 19))
          0, 1: olen = 8'd0;
          2: olen = $urandom_range(4, 255);
          default: olen = $urandom_range(1, 3);
        endcase
        put_opt(okind, olen);
      end
    end else if (kind < 75) begin
      // arp, mostly replies with the usual hardware length
      case ($urandom_range(0, 9))
        0: hln = $urandom_range(0, 24);
        1: hln = $urandom_range(0, 255);
        default: hln = 8'd6;
      endcase
      op = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 65535) : ARP_OP_REPLY;
      put_eth_hdr(ntag);
      put16(ETYPE_ARP);
      put_arp_body(hln, op, $urandom_range(0, 8));
    end else if (kind < 88) begin
      // too many tags or a foreign ethertype
      put_eth_hdr($urandom_range(0, TAG_LIMIT + 1));
      put16($urandom_range(0, 1) ? ETYPE_VLAN : $urandom_range(0, 65535));
      put_rand($urandom_range(0, 40));
    end else begin
      put_rand($urandom_range(1, 70));
    end
    if ($urandom_range(0, 4) == 0) drop = $urandom_range(1, fbuf.size());
    send_any(drop);
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and initial drive
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst                   = 1'b1;
    frame_if.valid        = 1'b0;
    frame_if.packet_byte  = '0;
    frame_if.last_byte    = 1'b0;
    frame_if.ingress_port = '0;
    frame_if.tag_present  = 1'b0;
    frame_if.tag_control  = '0;
    result_if.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // driver: one byte per transaction, idle bursts only between transactions
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst) begin
      frame_if.valid <= 1'b0;
      beat_live = 0;
      gap_left  = 0;
    end else begin
      if (beat_live && in_taken) beat_live = 0;
      if (!beat_live) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!hold_input && beat_queue.size() > 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            // first idle cycle of a burst
            gap_left = $urandom_range(0, 3);
          end else begin
            cur_beat  = beat_queue.pop_front();
            beat_live = 1;
          end
        end
      end
      frame_if.valid        <= beat_live;
      frame_if.packet_byte  <= cur_beat.data;
      frame_if.last_byte    <= cur_beat.last;
      frame_if.ingress_port <= cur_beat.port;
      frame_if.tag_present  <= cur_beat.tp;
      frame_if.tag_control  <= cur_beat.tc;
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on every accepted byte, check every accepted entry
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_taken <= frame_if.valid && frame_if.ready;
      // prediction comes first so a same-edge result always finds its entry
      if (frame_if.valid && frame_if.ready) begin
        seen_beat.data = frame_if.packet_byte;
        seen_beat.last = frame_if.last_byte;
        seen_beat.port = frame_if.ingress_port;
        seen_beat.tp   = frame_if.tag_present;
        seen_beat.tc   = frame_if.tag_control;
        predict_beat(seen_beat);
      end
      if (result_if.valid && result_if.ready) check_entry();
      // watchdog on cycles without any transaction
      if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------

  initial begin
    int rand_start_beats;
    int rand_start_results;
    bit paused;
    err_count    = 0;
    results_due  = 0;
    beats_queued = 0;
    hold_input   = 0;
    calm         = 0;
    paused       = 0;
    in_taken     = 0;
    beat_live    = 0;
    cur_beat     = '0;
    clear_parse();

    // arp reply of minimal length, all metadata bits high
    put_eth_hdr(0);
    put16(ETYPE_ARP);
    put_arp_body(8'd6, ARP_OP_REPLY, 0);
    send_frame(0, 16'hFFFF, 1'b1, 16'hFFFF);
    // arp request is ignored, metadata all low
    put_eth_hdr(0);
    put16(ETYPE_ARP);
    put_arp_body(8'd6, 16'h0001, 4);
    send_frame(0, 16'h0000, 1'b0, 16'h0000);
    // arp reply one byte short of the sender address
    put_eth_hdr(0);
    put16(ETYPE_ARP);
    put_arp_body(8'd6, ARP_OP_REPLY, 0);
    send_any(1);
    // both tag types, zero hardware length: address overlaps the mac
    put_rand(12);
    put16(ETYPE_VLAN);
    put_rand(2);
    put16(ETYPE_QINQ);
    put_rand(2);
    put16(ETYPE_ARP);
    put_arp_body(8'd0, ARP_OP_REPLY, 2);
    send_any(0);
    // largest hardware length
    put_eth_hdr(1);
    put16(ETYPE_ARP);
    put_arp_body(8'd255, ARP_OP_REPLY, 3);
    send_any(0);
    // one tag more than the parser skips
    put_eth_hdr(TAG_LIMIT + 1);
    put16(ETYPE_ARP);
    put_arp_body(8'd6, ARP_OP_REPLY, 0);
    send_any(0);
    // foreign ethertype
    put_eth_hdr(0);
    put16(16'h0800);
    put_rand(30);
    send_any(0);
    // frame ends inside the ethernet header, and a single-byte frame
    put_eth_hdr(0);
    put16(ETYPE_ARP);
    send_any(5);
    put_rand(1);
    send_any(0);
    // advertisement ending right after the target: ethernet source is used
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    send_any(0);
    // target link-layer option supplies the mac
    put_eth_hdr(2);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    put_opt(OPT_TGT_LLADDR, 8'd1);
    put_rand(5);
    send_any(0);
    // two other options before the target option
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    put_opt(8'd1, 8'd1);
    put_opt(8'd3, 8'd2);
    put_opt(OPT_TGT_LLADDR, 8'd1);
    send_any(0);
    // option budget used up before the target option
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    for (int i = 0; i < OPTION_LIMIT; i++) put_opt(8'd1, 8'd1);
    put_opt(OPT_TGT_LLADDR, 8'd1);
    send_any(0);
    // target option cut short by the frame end
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    put_opt(OPT_TGT_LLADDR, 8'd2);
    send_any(5);
    // zero-length target option with its mac present, then with the mac cut
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    put_opt(OPT_TGT_LLADDR, 8'd0);
    send_any(0);
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    put_opt(OPT_TGT_LLADDR, 8'd0);
    send_any(2);
    // zero-length option of another type stops the search
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    put_opt(8'd5, 8'd0);
    send_any(0);
    // wrong next header, wrong icmp type, cut ipv6 header, cut icmp body
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(8'd17, ICMP6_NA);
    send_any(0);
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, 8'd135);
    send_any(0);
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    send_any(30);
    put_eth_hdr(0);
    put16(ETYPE_IPV6);
    put_na_hdr(NEXT_HDR_ICMP6, ICMP6_NA);
    send_any(5);
    // arp reply long enough to saturate the byte offset
    put_eth_hdr(0);
    put16(ETYPE_ARP);
    put_arp_body(8'd6, ARP_OP_REPLY, LONG_BODY);
    send_any(0);

    // random frames, fed a few at a time so the entry count is up to date
    rand_start_beats   = beats_queued;
    rand_start_results = results_due;
    while (beats_queued - rand_start_beats < RAND_BEATS ||
           results_due - rand_start_results < RAND_RESULTS) begin
      while (beat_queue.size() > 64) @(posedge clk);
      make_random_frame();
      if (beats_queued - rand_start_beats >= CALM_BEATS) calm = 1;
      // hold the sender once until every owed entry has come out
      if (!paused && beats_queued - rand_start_beats >= RAND_BEATS / 2) begin
        paused     = 1;
        hold_input = 1;
        while (beat_live || nbr_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        hold_input = 0;
      end
    end
    calm = 1;

    // drain
    while (beat_queue.size() != 0 || beat_live || nbr_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
